// File: sv/kmr_pkg.sv
// Package for the keys-to-mouse motion ramp.
// Widths, register map and the speed-to-units helper; no dependencies.
package kmr_pkg;

  localparam int CFG_W   = 12;  // every config register
  localparam int SPEED_W = 13;  // signed Q8.4 speed
  localparam int MOVE_W  = 9;   // signed whole units
  localparam int ADDR_W  = 5;   // eight 32-bit registers
  localparam int IN_W    = 16;  // 12 field bits, padded to bytes
  localparam int OUT_W   = 40;  // 35 field bits, padded to bytes

  typedef enum logic [2:0] {
    REG_ACCEL        = 3'd0,
    REG_MAX_SPEED    = 3'd1,
    REG_BRAKE        = 3'd2,
    REG_BRAKE_SINGLE = 3'd3,
    REG_WHEEL_ACCEL  = 3'd4,
    REG_WHEEL_MAX    = 3'd5,
    REG_WHEEL_BRAKE  = 3'd6,
    REG_EXIT_HOLD    = 3'd7
  } reg_idx_t;

  localparam logic [CFG_W-1:0] ACCEL_RST        = 12'd16;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST    = 12'd240;
  localparam logic [CFG_W-1:0] BRAKE_RST        = 12'd16;
  localparam logic [CFG_W-1:0] BRAKE_SINGLE_RST = 12'd16;
  localparam logic [CFG_W-1:0] WHEEL_ACCEL_RST  = 12'd48;
  localparam logic [CFG_W-1:0] WHEEL_MAX_RST    = 12'd400;
  localparam logic [CFG_W-1:0] WHEEL_BRAKE_RST  = 12'd48;
  localparam logic [CFG_W-1:0] EXIT_HOLD_RST    = 12'd500;

  // Q8.4 speed to whole units, truncated toward zero.
  function automatic logic signed [MOVE_W-1:0] to_units(input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W-1:0] t;
    t = v[SPEED_W-1] ? v + 13'sd15 : v;
    return t[SPEED_W-1:4];
  endfunction

endpackage

// File: sv/kmr_ramp.sv
// One speed axis: accelerate per key, clamp to the limit, brake when idle.
// Depends on kmr_pkg.
module kmr_ramp (
  input  logic signed [kmr_pkg::SPEED_W-1:0] speed,
  input  logic                               key_pos,
  input  logic                               key_neg,
  input  logic        [kmr_pkg::CFG_W-1:0]   accel,
  input  logic        [kmr_pkg::CFG_W-1:0]   limit,
  input  logic        [kmr_pkg::CFG_W-1:0]   brake,
  output logic signed [kmr_pkg::SPEED_W-1:0] speed_next
);

  // two bits of headroom: speed +- accel reaches +-8190
  logic signed [kmr_pkg::SPEED_W+1:0] v0, v1, v2, v3, a, m, b;

  always_comb begin
    a  = $signed({3'b000, accel});
    m  = $signed({3'b000, limit});
    b  = $signed({3'b000, brake});
    v0 = {{2{speed[kmr_pkg::SPEED_W-1]}}, speed};

    // positive direction first, then negative
    v1 = v0;
    if (key_pos) begin
      if (v1 < m) v1 = v1 + a;
      if (v1 > m) v1 = m;
    end
    v2 = v1;
    if (key_neg) begin
      if (v2 > -m) v2 = v2 - a;
      if (v2 < -m) v2 = -m;
    end

    v3 = v2;
    if (!key_pos && !key_neg) begin
      if (v2 > b)       v3 = v2 - b;
      else if (v2 < -b) v3 = v2 + b;
      else              v3 = '0;
    end

    speed_next = v3[kmr_pkg::SPEED_W-1:0];
  end

endmodule

// File: sv/keys_to_mouse_motion_ramp.sv
// Top level of the keys-to-mouse motion ramp: APB register file, tick state
// and output register. Depends on kmr_pkg and kmr_ramp.
//
// Usage
//   s_* carries one item per timer tick: the sampled key states. m_* returns
//   exactly one item per input item: pointer x/y and wheel moves in whole
//   units, button press/release edges, the active flag and the exit flag.
//   The APB port holds eight 12-bit registers at byte addresses 4*i; write
//   them only while no item is in flight.
// Timing and throughput
//   The whole tick update (ramp, clamp, brake, edge and chord logic) is one
//   combinational pass from the accepted item and the state registers into
//   the result register: valid next cycle, one item per cycle unless stalled.
// Reset
//   rst (synchronous) zeroes speeds and held buttons, sets the block active,
//   clears the exit chord and the halt latch, and loads register defaults.
// Stall
//   s_tready is high whenever the result register is empty or being drained
//   this cycle, so a stalled receiver holds the result and back-pressures the
//   sender after a single buffered item; nothing is dropped.
// Exit
//   Once fn+quit has been held past exit_hold_ticks the block latches halted:
//   each item then yields zero moves/events with exit_done set until reset.
module keys_to_mouse_motion_ramp (
  input  logic                        clk,
  input  logic                        rst,
  // stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [3:0] move_keys, [5:4] wheel_keys, [8:6] button_keys, [9] fn_key,
  // [10] quit_key, [11] toggle_key, [15:12] zero
  input  logic [kmr_pkg::IN_W-1:0]    s_tdata,
  // stream out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [8:0] move_x, [17:9] move_y, [26:18] wheel_move, [29:27] press_events,
  // [32:30] release_events, [33] is_active, [34] exit_done, [39:35] zero
  output logic [kmr_pkg::OUT_W-1:0]   m_tdata,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW = kmr_pkg::CFG_W;
  localparam int SW = kmr_pkg::SPEED_W;

  // ---------------- configuration registers ----------------
  logic [CW-1:0] accel, max_speed, brake, brake_single;
  logic [CW-1:0] wheel_accel, wheel_max, wheel_brake, exit_hold_ticks;
  kmr_pkg::reg_idx_t reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = kmr_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel           <= kmr_pkg::ACCEL_RST;
      max_speed       <= kmr_pkg::MAX_SPEED_RST;
      brake           <= kmr_pkg::BRAKE_RST;
      brake_single    <= kmr_pkg::BRAKE_SINGLE_RST;
      wheel_accel     <= kmr_pkg::WHEEL_ACCEL_RST;
      wheel_max       <= kmr_pkg::WHEEL_MAX_RST;
      wheel_brake     <= kmr_pkg::WHEEL_BRAKE_RST;
      exit_hold_ticks <= kmr_pkg::EXIT_HOLD_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        kmr_pkg::REG_ACCEL:        accel           <= pwdata[CW-1:0];
        kmr_pkg::REG_MAX_SPEED:    max_speed       <= pwdata[CW-1:0];
        kmr_pkg::REG_BRAKE:        brake           <= pwdata[CW-1:0];
        kmr_pkg::REG_BRAKE_SINGLE: brake_single    <= pwdata[CW-1:0];
        kmr_pkg::REG_WHEEL_ACCEL:  wheel_accel     <= pwdata[CW-1:0];
        kmr_pkg::REG_WHEEL_MAX:    wheel_max       <= pwdata[CW-1:0];
        kmr_pkg::REG_WHEEL_BRAKE:  wheel_brake     <= pwdata[CW-1:0];
        kmr_pkg::REG_EXIT_HOLD:    exit_hold_ticks <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kmr_pkg::REG_ACCEL:        prdata = {20'd0, accel};
      kmr_pkg::REG_MAX_SPEED:    prdata = {20'd0, max_speed};
      kmr_pkg::REG_BRAKE:        prdata = {20'd0, brake};
      kmr_pkg::REG_BRAKE_SINGLE: prdata = {20'd0, brake_single};
      kmr_pkg::REG_WHEEL_ACCEL:  prdata = {20'd0, wheel_accel};
      kmr_pkg::REG_WHEEL_MAX:    prdata = {20'd0, wheel_max};
      kmr_pkg::REG_WHEEL_BRAKE:  prdata = {20'd0, wheel_brake};
      kmr_pkg::REG_EXIT_HOLD:    prdata = {20'd0, exit_hold_ticks};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- input fields ----------------
  logic [3:0] move_keys;
  logic [1:0] wheel_keys;
  logic [2:0] button_keys;
  logic       fn_key, quit_key, toggle_key;

  assign move_keys   = s_tdata[3:0];
  assign wheel_keys  = s_tdata[5:4];
  assign button_keys = s_tdata[8:6];
  assign fn_key      = s_tdata[9];
  assign quit_key    = s_tdata[10];
  assign toggle_key  = s_tdata[11];

  // ---------------- tick state ----------------
  logic signed [SW-1:0] x_speed, y_speed, wheel_speed;
  logic [2:0]           buttons_held;
  logic                 active_flag, toggle_seen, exit_holding, halted;
  logic [SW-1:0]        hold_count;

  logic signed [SW-1:0] x_speed_next, y_speed_next, wheel_speed_next;
  logic [2:0]           buttons_held_next;
  logic                 active_flag_next, toggle_seen_next, exit_holding_next, halted_next;
  logic [SW-1:0]        hold_count_next;

  logic signed [SW-1:0] x_ramp, y_ramp, w_ramp;
  logic                 moved_x, moved_y;
  logic [CW-1:0]        x_brake, y_brake;

  logic [kmr_pkg::OUT_W-1:0] result;
  logic                      accept;

  assign moved_x = move_keys[2] | move_keys[3];
  assign moved_y = move_keys[0] | move_keys[1];
  // idle pointer axis uses brake_single while the other axis moves
  assign x_brake = moved_y ? brake_single : brake;
  assign y_brake = moved_x ? brake_single : brake;

  kmr_ramp u_ramp_x (
    .speed(x_speed), .key_pos(move_keys[2]), .key_neg(move_keys[3]),
    .accel(accel), .limit(max_speed), .brake(x_brake), .speed_next(x_ramp)
  );

  kmr_ramp u_ramp_y (
    .speed(y_speed), .key_pos(move_keys[0]), .key_neg(move_keys[1]),
    .accel(accel), .limit(max_speed), .brake(y_brake), .speed_next(y_ramp)
  );

  kmr_ramp u_ramp_w (
    .speed(wheel_speed), .key_pos(wheel_keys[0]), .key_neg(wheel_keys[1]),
    .accel(wheel_accel), .limit(wheel_max), .brake(wheel_brake), .speed_next(w_ramp)
  );

  always_comb begin
    x_speed_next      = x_speed;
    y_speed_next      = y_speed;
    wheel_speed_next  = wheel_speed;
    buttons_held_next = buttons_held;
    active_flag_next  = active_flag;
    toggle_seen_next  = toggle_seen;
    exit_holding_next = exit_holding;
    hold_count_next   = hold_count;
    halted_next       = halted;
    result            = '0;

    // exit chord
    if (!halted) begin
      if (fn_key && quit_key) begin
        if (!exit_holding) begin
          exit_holding_next = 1'b1;
          hold_count_next   = '0;
        end else begin
          if (hold_count != {SW{1'b1}}) hold_count_next = hold_count + 1'b1;
          if (hold_count_next > {1'b0, exit_hold_ticks}) halted_next = 1'b1;
        end
      end else begin
        exit_holding_next = 1'b0;
      end
    end

    if (!halted_next) begin
      // activate chord, edge only
      if (fn_key && toggle_key) begin
        if (!toggle_seen) begin
          active_flag_next = !active_flag;
          toggle_seen_next = 1'b1;
        end
      end else begin
        toggle_seen_next = 1'b0;
      end

      if (active_flag_next) begin
        x_speed_next      = x_ramp;
        y_speed_next      = y_ramp;
        wheel_speed_next  = w_ramp;
        buttons_held_next = button_keys;
        result[8:0]   = kmr_pkg::to_units(x_ramp);
        result[17:9]  = kmr_pkg::to_units(y_ramp);
        result[26:18] = kmr_pkg::to_units(w_ramp);
        result[29:27] = button_keys & ~buttons_held;
        result[32:30] = buttons_held & ~button_keys;
      end
    end

    result[33] = active_flag_next;
    result[34] = halted_next;
  end

  // ---------------- handshake and result register ----------------
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_speed      <= '0;
      y_speed      <= '0;
      wheel_speed  <= '0;
      buttons_held <= '0;
      active_flag  <= 1'b1;
      toggle_seen  <= 1'b0;
      exit_holding <= 1'b0;
      hold_count   <= '0;
      halted       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        x_speed      <= x_speed_next;
        y_speed      <= y_speed_next;
        wheel_speed  <= wheel_speed_next;
        buttons_held <= buttons_held_next;
        active_flag  <= active_flag_next;
        toggle_seen  <= toggle_seen_next;
        exit_holding <= exit_holding_next;
        hold_count   <= hold_count_next;
        halted       <= halted_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) m_tdata <= result;
  end

endmodule

// File: dv/keys_to_mouse_motion_ramp_tb.sv
// Self-checking testbench for keys_to_mouse_motion_ramp: key-state ticks in,
// mouse reports out, registers over APB. Depends on kmr_pkg and the block RTL.
`timescale 1ns / 1ps

module keys_to_mouse_motion_ramp_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_TICKS = 150;
  localparam int MAX_REPORTS = 10;

  localparam int CW = kmr_pkg::CFG_W;
  localparam int SW = kmr_pkg::SPEED_W;
  localparam int MW = kmr_pkg::MOVE_W;

  // one tick of sampled key states
  typedef struct packed {
    logic       toggle_key;
    logic       quit_key;
    logic       fn_key;
    logic [2:0] button_keys;
    logic [1:0] wheel_keys;
    logic [3:0] move_keys;
  } key_tick_t;

  // one mouse report, same field order as m_tdata from the low bit up
  typedef struct packed {
    logic                 exit_done;
    logic                 is_active;
    logic [2:0]           release_events;
    logic [2:0]           press_events;
    logic signed [MW-1:0] wheel_move;
    logic signed [MW-1:0] move_y;
    logic signed [MW-1:0] move_x;
  } mouse_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [kmr_pkg::IN_W-1:0]   s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [kmr_pkg::OUT_W-1:0]  m_tdata;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [kmr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  keys_to_mouse_motion_ramp dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [3:0] move, [5:4] wheel, [8:6] buttons, [9] fn, [10] quit, [11] toggle
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [8:0] x, [17:9] y, [26:18] wheel, [29:27] press, [32:30] release,
                           // [33] active, [34] exit
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_tick_t     pending_ticks[$];     // waiting to be driven
  mouse_report_t expected_reports[$];  // predicted, waiting for the block
  int            err_count = 0;
  int            cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and tick state, updated per accepted item.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cfg [8] = '{kmr_pkg::ACCEL_RST, kmr_pkg::MAX_SPEED_RST,
                             kmr_pkg::BRAKE_RST, kmr_pkg::BRAKE_SINGLE_RST,
                             kmr_pkg::WHEEL_ACCEL_RST, kmr_pkg::WHEEL_MAX_RST,
                             kmr_pkg::WHEEL_BRAKE_RST, kmr_pkg::EXIT_HOLD_RST};
  logic signed [SW-1:0] x_spd = '0, y_spd = '0, w_spd = '0;
  logic [2:0]           held_btn = '0;
  logic [SW-1:0]        hold_cnt = '0;
  bit                   active_q = 1'b1;
  bit                   toggle_armed = 1'b0;  // chord already seen this press
  bit                   exit_armed = 1'b0;
  bit                   halted_q = 1'b0;

  function automatic int speed_up(int v, int a, int m);
    if (v < m) v = v + a;
    if (v > m) v = m;
    return v;
  endfunction

  function automatic int speed_down(int v, int a, int m);
    if (v > -m) v = v - a;
    if (v < -m) v = -m;
    return v;
  endfunction

  // brake toward zero without crossing it
  function automatic int coast(int v, int b);
    if (v > b) return v - b;
    if (v < -b) return v + b;
    return 0;
  endfunction

  function automatic void advance_tick(input key_tick_t t);
    mouse_report_t r;
    int xs, ys, ws, acc, lim, wacc, wlim;
    bit mvx, mvy, mvw;
    r = '0;
    xs = x_spd;
    ys = y_spd;
    ws = w_spd;
    acc = cfg[kmr_pkg::REG_ACCEL];
    lim = cfg[kmr_pkg::REG_MAX_SPEED];
    wacc = cfg[kmr_pkg::REG_WHEEL_ACCEL];
    wlim = cfg[kmr_pkg::REG_WHEEL_MAX];
    mvx = 1'b0;
    mvy = 1'b0;
    mvw = 1'b0;

    // exit chord is looked at first; the tick that fires it already halts
    if (!halted_q) begin
      if (t.fn_key && t.quit_key) begin
        if (!exit_armed) begin
          exit_armed = 1'b1;
          hold_cnt = '0;
        end else begin
          if (hold_cnt < 13'd8191) hold_cnt = hold_cnt + 1'b1;
          if (hold_cnt > cfg[kmr_pkg::REG_EXIT_HOLD]) halted_q = 1'b1;
        end
      end else begin
        exit_armed = 1'b0;
      end
    end

    if (!halted_q) begin
      // activate chord flips only on its first tick
      if (t.fn_key && t.toggle_key) begin
        if (!toggle_armed) begin
          active_q = !active_q;
          toggle_armed = 1'b1;
        end
      end else begin
        toggle_armed = 1'b0;
      end

      if (active_q) begin
        // opposite keys: down/right/wheel-up applied before up/left/wheel-down
        if (t.move_keys[0]) begin mvy = 1'b1; ys = speed_up(ys, acc, lim); end
        if (t.move_keys[1]) begin mvy = 1'b1; ys = speed_down(ys, acc, lim); end
        if (t.move_keys[2]) begin mvx = 1'b1; xs = speed_up(xs, acc, lim); end
        if (t.move_keys[3]) begin mvx = 1'b1; xs = speed_down(xs, acc, lim); end

        r.press_events = t.button_keys & ~held_btn;
        r.release_events = held_btn & ~t.button_keys;
        held_btn = t.button_keys;

        if (t.wheel_keys[0]) begin mvw = 1'b1; ws = speed_up(ws, wacc, wlim); end
        if (t.wheel_keys[1]) begin mvw = 1'b1; ws = speed_down(ws, wacc, wlim); end

        // idle pointer axis uses the single-axis brake while the other one moves
        if (!mvx) xs = coast(xs, mvy ? cfg[kmr_pkg::REG_BRAKE_SINGLE]
                                     : cfg[kmr_pkg::REG_BRAKE]);
        if (!mvy) ys = coast(ys, mvx ? cfg[kmr_pkg::REG_BRAKE_SINGLE]
                                     : cfg[kmr_pkg::REG_BRAKE]);
        if (!mvw) ws = coast(ws, cfg[kmr_pkg::REG_WHEEL_BRAKE]);

        x_spd = SW'(xs);
        y_spd = SW'(ys);
        w_spd = SW'(ws);
        // int division truncates toward zero
        r.move_x = MW'(xs / 16);
        r.move_y = MW'(ys / 16);
        r.wheel_move = MW'(ws / 16);
      end
    end

    r.is_active = active_q;
    r.exit_done = halted_q;
    expected_reports.insert(expected_reports.size(), r);
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps; prediction on acceptance.
  // ---------------------------------------------------------------------------
  key_tick_t cur_tick;
  int        burst_left = 1;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_tick(cur_tick);
      // next item only when the slot is free; a stalled item holds still
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          cur_tick = pending_ticks.pop_front();
          s_tdata <= {{(kmr_pkg::IN_W - $bits(key_tick_t)){1'b0}}, cur_tick};
          s_tvalid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stall pattern and in-order check of every report.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin : monitor
    mouse_report_t got, want;
    bit            rdy;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(mouse_report_t)-1:0];
      if (expected_reports.size() == 0) begin
        note_error($sformatf("report with nothing expected, tdata=%h", m_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want)
          note_error($sformatf({"report mismatch: exp x=%0d y=%0d w=%0d prs=%b rel=%b ",
                                "act=%b ex=%b / got x=%0d y=%0d w=%0d prs=%b rel=%b act=%b ex=%b"},
                               want.move_x, want.move_y, want.wheel_move, want.press_events,
                               want.release_events, want.is_active, want.exit_done,
                               got.move_x, got.move_y, got.wheel_move, got.press_events,
                               got.release_events, got.is_active, got.exit_done));
      end
    end

    // stall mode is redrawn when its run ends: open, light, heavy, periodic
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 3) != 0);
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = (cycle_count % 5 != 0);
    endcase
    m_tready <= rdy;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic key_tick_t make_tick(logic [3:0] mv, logic [1:0] wh, logic [2:0] bt,
                                          logic f, logic q, logic tg);
    key_tick_t t;
    t.move_keys = mv;
    t.wheel_keys = wh;
    t.button_keys = bt;
    t.fn_key = f;
    t.quit_key = q;
    t.toggle_key = tg;
    return t;
  endfunction

  // append to the driver's queue
  function automatic void add_tick(input key_tick_t t);
    pending_ticks.insert(pending_ticks.size(), t);
  endfunction

  // keys held over several ticks with occasional flips, some fully random ticks
  logic [11:0] held_keys = '0;
  int          chord_run = 0;

  function automatic key_tick_t random_tick();
    key_tick_t t;
    if ($urandom_range(0, 9) == 0) begin
      held_keys = 12'($urandom());
    end else begin
      for (int b = 0; b < 12; b++)
        if ($urandom_range(0, 9) == 0) held_keys[b] = ~held_keys[b];
    end
    // keep the exit chord short so random phases never halt the block
    if (held_keys[9] && held_keys[10]) begin
      chord_run++;
      if (chord_run > 20) begin
        held_keys[10] = 1'b0;
        chord_run = 0;
      end
    end else begin
      chord_run = 0;
    end
    t = held_keys;
    return t;
  endfunction

  function automatic logic [CW-1:0] pick_value(input kmr_pkg::reg_idx_t r);
    if (r == kmr_pkg::REG_EXIT_HOLD)
      return ($urandom_range(0, 3) == 0) ? 12'd4095 : CW'($urandom_range(30, 4095));
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 12'd4095;
      2, 3, 4: return CW'($urandom_range(1, 48));
      5: return CW'($urandom_range(48, 600));
      default: return CW'($urandom_range(0, 4095));
    endcase
  endfunction

  // setup cycle, then access cycle until pready
  task automatic apb_xfer(input bit wr, input kmr_pkg::reg_idx_t r, input logic [31:0] d,
                          output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write with random upper bits, then read back the 12-bit value
  task automatic cfg_write(input kmr_pkg::reg_idx_t r, input logic [CW-1:0] v);
    logic [31:0] d, rd;
    d = $urandom();
    d[CW-1:0] = v;
    apb_xfer(1'b1, r, d, rd);
    cfg[r] = v;
    apb_xfer(1'b0, r, $urandom(), rd);
    if (rd[CW-1:0] !== v)
      note_error($sformatf("register %s read %h, wrote %h", r.name(), rd[CW-1:0], v));
  endtask

  // every item accepted and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || s_tvalid || expected_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset registers: ramps, opposite keys, buttons, activate chord
    @(negedge clk);
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h1, 2'd0, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h1, 2'd0, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h3, 2'd0, 3'd0, 0, 0, 0));  // up and down
    add_tick(make_tick(4'h4, 2'd0, 3'd0, 0, 0, 0));  // y brakes single-axis
    add_tick(make_tick(4'hC, 2'd0, 3'd0, 0, 0, 0));  // left and right
    add_tick(make_tick(4'hF, 2'd1, 3'd7, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd3, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd2, 3'd5, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd0, 3'd5, 1, 0, 1));  // go inactive
    add_tick(make_tick(4'hF, 2'd3, 3'd2, 1, 0, 1));  // chord held, no flip
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 1, 0, 1));  // active again
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));

    // largest ramp, no braking: speeds hit the full Q8.4 range
    wait_idle();
    cfg_write(kmr_pkg::REG_ACCEL, 12'd4095);
    cfg_write(kmr_pkg::REG_MAX_SPEED, 12'd4095);
    cfg_write(kmr_pkg::REG_BRAKE, 12'd0);
    cfg_write(kmr_pkg::REG_BRAKE_SINGLE, 12'd0);
    cfg_write(kmr_pkg::REG_WHEEL_ACCEL, 12'd4095);
    cfg_write(kmr_pkg::REG_WHEEL_MAX, 12'd4095);
    cfg_write(kmr_pkg::REG_WHEEL_BRAKE, 12'd0);
    @(negedge clk);
    add_tick(make_tick(4'h5, 2'd1, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h5, 2'd1, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'hA, 2'd2, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'hA, 2'd2, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));

    // maximum lowered under the held speed, hardest brakes, exit hold of 1
    wait_idle();
    cfg_write(kmr_pkg::REG_MAX_SPEED, 12'd100);
    cfg_write(kmr_pkg::REG_WHEEL_MAX, 12'd100);
    cfg_write(kmr_pkg::REG_BRAKE, 12'd4095);
    cfg_write(kmr_pkg::REG_BRAKE_SINGLE, 12'd4095);
    cfg_write(kmr_pkg::REG_WHEEL_BRAKE, 12'd4095);
    cfg_write(kmr_pkg::REG_EXIT_HOLD, 12'd1);
    @(negedge clk);
    add_tick(make_tick(4'h8, 2'd0, 3'd0, 0, 0, 0));  // clamps to new max
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 1, 1, 0));
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 1, 1, 0));  // one short of firing
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 0, 0, 0));

    // random phases; odd phases also pause midway until all reports are back
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        if (ph == 1)
          cfg_write(kmr_pkg::reg_idx_t'(r), 12'd4095);
        else if (ph == 2 && kmr_pkg::reg_idx_t'(r) != kmr_pkg::REG_EXIT_HOLD)
          cfg_write(kmr_pkg::reg_idx_t'(r), 12'd0);
        else
          cfg_write(kmr_pkg::reg_idx_t'(r), pick_value(kmr_pkg::reg_idx_t'(r)));
      end
      @(negedge clk);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (ph % 2 == 1 && n == PHASE_TICKS / 2) begin
          wait_idle();
          @(negedge clk);
        end
        add_tick(random_tick());
      end
    end

    // exit hold of zero fires on the second held tick; after that only halted reports
    wait_idle();
    cfg_write(kmr_pkg::REG_EXIT_HOLD, 12'd0);
    @(negedge clk);
    add_tick(make_tick(4'h0, 2'd0, 3'd0, 1, 1, 0));
    add_tick(make_tick(4'h5, 2'd1, 3'd7, 1, 1, 1));
    for (int n = 0; n < 12; n++) add_tick(random_tick());

    wait_idle();
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
sv/kmr_pkg.sv
sv/kmr_ramp.sv
sv/keys_to_mouse_motion_ramp.sv
dv/keys_to_mouse_motion_ramp_tb.sv
